// ===== rtl/qsh_pkg.sv =====
// qsh_pkg: shared types and constants for the queue/stack/heap trace checker.
// No dependencies.
package qsh_pkg;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd0;
    localparam logic [2:0] VERDICT_NOT_SURE   = 3'd1;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd2;
    localparam logic [2:0] VERDICT_STACK      = 3'd3;
    localparam logic [2:0] VERDICT_PRIO       = 3'd4;

    localparam int FLAG_FIFO = 0;
    localparam int FLAG_LIFO = 1;
    localparam int FLAG_HEAP = 2;

    // signed compare a > b
    function automatic logic sgt(input logic signed [31:0] a, input logic signed [31:0] b);
        sgt = a > b;
    endfunction

    function automatic logic [2:0] verdict_of(input logic [2:0] f);
        logic [2:0] v;
        unique case (f)
            3'b000:  v = VERDICT_IMPOSSIBLE;
            3'b001:  v = VERDICT_QUEUE;
            3'b010:  v = VERDICT_STACK;
            3'b100:  v = VERDICT_PRIO;
            default: v = VERDICT_NOT_SURE;
        endcase
        verdict_of = v;
    endfunction

endpackage

// ===== rtl/qsh_heap.sv =====
// qsh_heap: max-heap store with an iterative sift sequencer and one shared comparator.
// Depends on qsh_pkg.
module qsh_heap #(
    parameter int CAPACITY = 1024,
    parameter int AW = 10,
    parameter int CW = 11
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  logic                     push,
    input  logic                     pop,
    input  logic signed [31:0]       value,
    output logic [CW-1:0]            count,
    output logic signed [31:0]       top,
    output logic                     done
);
    import qsh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_LAST, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_TOP
    } state_t;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      pos_reg;
    logic [CW-1:0]      pick_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] lval_reg;
    logic signed [31:0] top_reg;
    logic               done_reg;
    logic               cmp;
    logic signed [31:0] cmp_a;
    logic signed [31:0] cmp_b;
    logic [CW-1:0]      up;
    logic [CW:0]        left;

    assign up   = (pos_reg - CW'(1)) >> 1;
    assign left = {pos_reg, 1'b1};
    assign cmp  = sgt(cmp_a, cmp_b);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        raddr = '0;
        we    = 1'b0;
        waddr = pos_reg[AW-1:0];
        wdata = val_reg;
        cmp_a = rdata_reg;
        cmp_b = val_reg;
        unique case (state_reg)
            S_IDLE:    raddr = AW'(count_reg - CW'(1));
            S_UP_RD:   raddr = up[AW-1:0];
            S_UP_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = rdata_reg;
                we    = 1'b1;
                wdata = (pos_reg != '0 && cmp) ? rdata_reg : val_reg;
            end
            S_DN_LAST: raddr = left[AW-1:0];
            S_DN_RDL:  raddr = AW'(left + (CW+1)'(1));
            S_DN_RDR:
            begin
                raddr = '0;
                cmp_a = rdata_reg;
                cmp_b = lval_reg;
            end
            S_DN_CMP:
            begin
                cmp_a = lval_reg;
                cmp_b = val_reg;
                we    = 1'b1;
                wdata = cmp ? lval_reg : val_reg;
            end
            S_TOP:     raddr = '0;
            default:   raddr = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            pos_reg   <= '0;
            pick_reg  <= '0;
            val_reg   <= '0;
            lval_reg  <= '0;
            top_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (clear)
                        count_reg <= '0;
                    else if (push)
                    begin
                        val_reg   <= value;
                        pos_reg   <= count_reg;
                        count_reg <= count_reg + CW'(1);
                        state_reg <= (count_reg == '0) ? S_UP_CMP : S_UP_RD;
                        lval_reg  <= value;
                    end
                    else if (pop)
                    begin
                        count_reg <= count_reg - CW'(1);
                        pos_reg   <= '0;
                        state_reg <= S_DN_LAST;
                    end
                end
                S_UP_RD:   state_reg <= S_UP_CMP;
                S_UP_CMP:
                begin
                    if (pos_reg != '0 && cmp)
                    begin
                        pos_reg   <= up;
                        state_reg <= (up == '0) ? S_UP_CMP : S_UP_RD;
                    end
                    else
                        state_reg <= S_TOP;
                end
                S_DN_LAST:
                begin
                    // last element arrives from the idle read on the first level only
                    if (pos_reg == '0)
                        val_reg <= rdata_reg;
                    if (left >= (CW+1)'(count_reg))
                    begin
                        if (count_reg == '0)
                            state_reg <= S_TOP;
                        else
                            state_reg <= S_DN_CMP;
                        lval_reg <= (pos_reg == '0) ? rdata_reg : val_reg;
                    end
                    else
                        state_reg <= S_DN_RDL;
                end
                S_DN_RDL:
                begin
                    lval_reg <= rdata_reg;
                    pick_reg <= left[CW-1:0];
                    if (left + (CW+1)'(1) < (CW+1)'(count_reg))
                        state_reg <= S_DN_RDR;
                    else
                        state_reg <= S_DN_CMP;
                end
                S_DN_RDR:
                begin
                    if (cmp)
                    begin
                        lval_reg <= rdata_reg;
                        pick_reg <= CW'(left + (CW+1)'(1));
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (cmp && pick_reg != pos_reg)
                    begin
                        pos_reg   <= pick_reg;
                        state_reg <= S_DN_LAST;
                    end
                    else
                        state_reg <= S_TOP;
                end
                S_TOP:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
            // root is read in S_TOP, after the last write of the sift
            if (done_reg)
                top_reg <= rdata_reg;
        end
    end

    assign count = count_reg;
    assign top   = top_reg;
    assign done  = done_reg;

endmodule

// ===== rtl/queue_stack_heap_trace_checker.sv =====
// queue_stack_heap_trace_checker: top level, FIFO/LIFO stores and item sequencer.
// Depends on qsh_pkg and qsh_heap.
//
// Usage: raise start with op and value while busy is low. The result shows on
// the outputs for one cycle with done high. After the accepting edge the
// sequencer passes S_RD and S_OUT for a restart, an unused code, a dropped push
// or a push with the heap discipline already cleared, and S_RD, S_CMP and S_OUT
// for a pop that leaves the heap alone. The heap sift adds S_HEAP, served by
// the single compare unit and one RAM read port: a push climbs one level per
// S_UP_CMP compare, reading the parent in S_UP_RD, and a pop descends one level
// through S_DN_LAST, S_DN_RDL, S_DN_RDR and S_DN_CMP. A new item can
// be accepted in the cycle that done is high. The receiver cannot stall the
// result. Stores are plain RAMs with no clearing pass.
module queue_stack_heap_trace_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic signed [31:0] value,
    output logic        done,
    output logic        may_be_fifo,
    output logic        may_be_lifo,
    output logic        may_be_max_heap,
    output logic [2:0]  verdict,
    output logic        overflow
);
    import qsh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] { S_IDLE, S_RD, S_CMP, S_HEAP, S_OUT } state_t;

    state_t             state_reg;
    logic [1:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [2:0]         flags_reg;
    logic               ovf_reg;
    logic [AW-1:0]      fhead_reg;
    logic [CW-1:0]      fcount_reg;
    logic [CW-1:0]      lcount_reg;
    logic               done_reg;

    logic signed [31:0] fmem [CAPACITY];
    logic signed [31:0] lmem [CAPACITY];
    logic signed [31:0] frd_reg;
    logic signed [31:0] lrd_reg;
    logic [AW-1:0]      fslot;
    logic [CW:0]        fsum;

    logic               h_clear;
    logic               h_push;
    logic               h_pop;
    logic [CW-1:0]      h_count;
    logic signed [31:0] h_top;
    logic               h_done;
    logic [CW-1:0]      live;
    logic               full;
    logic               fifo_ok;
    logic               lifo_ok;
    logic               heap_ok;

    assign fsum  = (CW+1)'(fhead_reg) + (CW+1)'(fcount_reg);
    assign fslot = (fsum >= (CW+1)'(CAPACITY)) ? AW'(fsum - (CW+1)'(CAPACITY)) : AW'(fsum);

    always_comb
    begin
        priority if (flags_reg[FLAG_FIFO]) live = fcount_reg;
        else if (flags_reg[FLAG_LIFO])     live = lcount_reg;
        else if (flags_reg[FLAG_HEAP])     live = h_count;
        else                               live = '0;
    end
    assign full = (live == CW'(CAPACITY));

    assign fifo_ok = fcount_reg != '0 && frd_reg == val_reg;
    assign lifo_ok = lcount_reg != '0 && lrd_reg == val_reg;
    assign heap_ok = h_count != '0 && h_top == val_reg;

    // FIFO and stack RAMs: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD && op_reg == OP_PUSH && !full)
        begin
            if (flags_reg[FLAG_FIFO])
                fmem[fslot] <= val_reg;
            if (flags_reg[FLAG_LIFO])
                lmem[lcount_reg[AW-1:0]] <= val_reg;
        end
        frd_reg <= fmem[fhead_reg];
        lrd_reg <= lmem[AW'(lcount_reg - CW'(1))];
    end

    assign h_clear = state_reg == S_RD && op_reg == OP_RESTART;
    assign h_push  = state_reg == S_RD && op_reg == OP_PUSH && !full && flags_reg[FLAG_HEAP];
    assign h_pop   = state_reg == S_CMP && op_reg == OP_POP && flags_reg[FLAG_HEAP] && heap_ok;

    qsh_heap #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (h_clear),
        .push  (h_push),
        .pop   (h_pop),
        .value (val_reg),
        .count (h_count),
        .top   (h_top),
        .done  (h_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_PUSH;
            val_reg    <= '0;
            flags_reg  <= 3'b111;
            ovf_reg    <= 1'b0;
            fhead_reg  <= '0;
            fcount_reg <= '0;
            lcount_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= op;
                        val_reg   <= value;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_OUT;
                    unique case (op_reg)
                        OP_PUSH:
                        begin
                            if (full)
                                ovf_reg <= 1'b1;
                            else
                            begin
                                if (flags_reg[FLAG_FIFO]) fcount_reg <= fcount_reg + CW'(1);
                                if (flags_reg[FLAG_LIFO]) lcount_reg <= lcount_reg + CW'(1);
                                if (flags_reg[FLAG_HEAP]) state_reg <= S_HEAP;
                            end
                        end
                        OP_POP: state_reg <= S_CMP;
                        OP_RESTART:
                        begin
                            flags_reg  <= 3'b111;
                            fhead_reg  <= '0;
                            fcount_reg <= '0;
                            lcount_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                S_CMP:
                begin
                    state_reg <= S_OUT;
                    if (flags_reg[FLAG_FIFO])
                    begin
                        if (!fifo_ok)
                            flags_reg[FLAG_FIFO] <= 1'b0;
                        else
                        begin
                            fhead_reg  <= (fhead_reg == AW'(CAPACITY - 1)) ? '0
                                          : fhead_reg + AW'(1);
                            fcount_reg <= fcount_reg - CW'(1);
                        end
                    end
                    if (flags_reg[FLAG_LIFO])
                    begin
                        if (!lifo_ok)
                            flags_reg[FLAG_LIFO] <= 1'b0;
                        else
                            lcount_reg <= lcount_reg - CW'(1);
                    end
                    if (flags_reg[FLAG_HEAP])
                    begin
                        if (!heap_ok)
                            flags_reg[FLAG_HEAP] <= 1'b0;
                        else
                            state_reg <= S_HEAP;
                    end
                end
                S_HEAP:
                begin
                    if (h_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign may_be_fifo     = flags_reg[FLAG_FIFO];
    assign may_be_lifo     = flags_reg[FLAG_LIFO];
    assign may_be_max_heap = flags_reg[FLAG_HEAP];
    assign verdict         = verdict_of(flags_reg);
    assign overflow        = ovf_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    a_counts_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flags_reg[FLAG_FIFO] && flags_reg[FLAG_LIFO]) |-> fcount_reg == lcount_reg)
        else $error("live stores out of step");

endmodule
